// ===== design/wis_pkg.sv =====
// Shared types and constants for the weighted interval scheduling core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wis_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int TIME_W        = 16;
    localparam int VAL_W         = 20;
    localparam int IDX_OUT_W     = 5;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] weight;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] table_index;
        logic [VAL_W-1:0]     best_value;
        logic                 last_result;
    } out_item_t;

    // one interval as held in the sorted row
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] weight;
    } interval_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } wis_state_t;

    typedef struct packed {
        logic load_item;
        logic init;
        logic fetch;
        logic scan_step;
        logic take_latch;
        logic write_entry;
        logic emit_init;
        logic emit_item;
        logic clear_count;
    } wis_cmd_t;

    typedef struct packed {
        logic scan_hit;
        logic k_last;
        logic emit_last;
        logic out_free;
    } wis_sts_t;

endpackage

`default_nettype wire

// ===== design/wis_ctrl.sv =====
// Sequencer for the weighted interval scheduling core: load, table pass, emit.
// Depends on wis_pkg; drives commands into wis_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module wis_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_last,
    output logic                   s_ready,
    input  wire wis_pkg::wis_sts_t sts,
    output wis_pkg::wis_cmd_t      cmd
);
    import wis_pkg::*;

    wis_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_hit) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = sts.k_last ? ST_EMIT : ST_FETCH;
            end
            ST_EMIT: begin
                if (sts.out_free && sts.emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
                cmd.init      = s_valid && s_last;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            ST_SCAN: begin
                cmd.take_latch = sts.scan_hit;
                cmd.scan_step  = !sts.scan_hit;
            end
            ST_WRITE: begin
                cmd.write_entry = 1'b1;
                cmd.emit_init   = sts.k_last;
            end
            ST_EMIT: begin
                cmd.emit_item   = sts.out_free;
                cmd.clear_count = sts.out_free && sts.emit_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/wis_dp.sv =====
// Datapath: insertion-sorted interval row, table registers, scan counters,
// output register. Depends on wis_pkg; controlled by wis_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module wis_dp #(
    parameter int MAX_ITEMS = wis_pkg::MAX_ITEMS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire wis_pkg::in_item_t s_item,
    input  wire wis_pkg::wis_cmd_t cmd,
    output wis_pkg::wis_sts_t      sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output wis_pkg::out_item_t     m_item
);
    import wis_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
    localparam int CELL_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    interval_t          cell_reg [MAX_ITEMS];
    logic [VAL_W-1:0]   best_mem [1:MAX_ITEMS];
    logic [IDX_W-1:0]   count_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [TIME_W-1:0]  start_k_reg;
    logic [TIME_W-1:0]  weight_k_reg;
    logic [VAL_W-1:0]   take_reg;
    logic [VAL_W-1:0]   prev_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic [MAX_ITEMS-1:0] gt;
    logic [MAX_ITEMS-1:0] ge;
    logic                 full;
    logic [IDX_W-1:0]     i_m1;
    logic [VAL_W-1:0]     best_rd;
    logic [VAL_W:0]       take_sum;
    logic [VAL_W-1:0]     take_sat;
    logic [VAL_W-1:0]     entry_val;
    logic [IDX_W:0]       k_inc;
    interval_t            new_cell;
    interval_t            cell_k;

    assign full     = (count_reg == IDX_W'(MAX_ITEMS));
    assign new_cell = '{start_time:  s_item.start_time,
                        finish_time: s_item.finish_time,
                        weight:      s_item.weight};

    // Stable insertion: the new interval lands after every entry whose
    // finish is not greater; entries above it move up one place.
    for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
        localparam logic [IDX_W-1:0] C_IDX = IDX_W'(c);
        assign gt[c] = (C_IDX < count_reg) &&
                       (cell_reg[c].finish_time > s_item.finish_time);
        assign ge[c] = gt[c] || (C_IDX == count_reg);

        if (c == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (cmd.load_item && !full && ge[c]) begin
                    cell_reg[c] <= new_cell;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (cmd.load_item && !full && ge[c]) begin
                    cell_reg[c] <= gt[c-1] ? cell_reg[c-1] : new_cell;
                end
            end
        end
    end

    assign i_m1    = i_reg - 1'b1;
    assign cell_k  = cell_reg[k_reg[CELL_W-1:0]];
    assign best_rd = (i_reg == '0) ? '0 : best_mem[i_reg];

    assign take_sum  = {1'b0, {(VAL_W - TIME_W){1'b0}}, weight_k_reg} + {1'b0, best_rd};
    assign take_sat  = take_sum[VAL_W] ? {VAL_W{1'b1}} : take_sum[VAL_W-1:0];
    assign entry_val = (take_reg > prev_reg) ? take_reg : prev_reg;
    assign k_inc     = {1'b0, k_reg} + 1'b1;

    assign sts.scan_hit  = (i_reg == '0) ||
                           (cell_reg[i_m1[CELL_W-1:0]].finish_time <= start_k_reg);
    assign sts.k_last    = (k_inc == {1'b0, count_reg});
    assign sts.emit_last = (i_reg == count_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_count) begin
                count_reg <= '0;
            end else if (cmd.load_item && !full) begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.init) begin
                k_reg <= '0;
            end else if (cmd.write_entry) begin
                k_reg <= k_inc[IDX_W-1:0];
            end

            if (cmd.fetch) begin
                i_reg <= k_reg;
            end else if (cmd.scan_step) begin
                i_reg <= i_m1;
            end else if (cmd.emit_init) begin
                i_reg <= '0;
            end else if (cmd.emit_item) begin
                i_reg <= i_reg + 1'b1;
            end

            if (cmd.emit_item) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            prev_reg <= '0;
        end else if (cmd.write_entry) begin
            prev_reg <= entry_val;
        end
        if (cmd.write_entry) begin
            best_mem[k_inc[IDX_W-1:0]] <= entry_val;
        end
        if (cmd.fetch) begin
            start_k_reg  <= cell_k.start_time;
            weight_k_reg <= cell_k.weight;
        end
        if (cmd.take_latch) begin
            take_reg <= take_sat;
        end
        if (cmd.emit_item) begin
            m_item_reg.table_index <= IDX_OUT_W'(i_reg);
            m_item_reg.best_value  <= best_rd;
            m_item_reg.last_result <= (i_reg == count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ===== design/weighted_interval_scheduling_core.sv =====
// Top level of the weighted interval scheduling core.
// Depends on wis_pkg, wis_ctrl and wis_dp.
//
//  channel   ports                      carries
//  input     s_valid s_ready s_item     one interval (start, finish, weight, last)
//  result    m_valid m_ready m_item     one table entry (index, value, last)
//
// While loading, intervals are taken one per cycle and inserted in finish order.
// After the last one, each entry k+1 fetches interval k, scans backward through the
// stored intervals (one stored interval per cycle) for the latest compatible one,
// and is written; then n+1 entries leave at one per cycle when m_ready is high.
// Input is held off from the last interval until the final entry is in the
// output register. Reset is synchronous on aresetn and empties the set.
`timescale 1ns / 1ps
`default_nettype none

module weighted_interval_scheduling_core #(
    parameter int MAX_ITEMS = wis_pkg::MAX_ITEMS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire wis_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output wis_pkg::out_item_t      m_item
);
    import wis_pkg::*;

    wis_cmd_t cmd;
    wis_sts_t sts;

    wis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_item.last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wis_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for weighted_interval_scheduling_core.
// Depends on wis_pkg and the core; sets of intervals go in on a valid/ready
// channel and the full table that comes back is checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
    import wis_pkg::*;

    localparam int SET_CAP    = MAX_ITEMS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 40;
    localparam int RANDOM_GOAL = 150;
    localparam logic [VAL_W-1:0] VALUE_CEIL = '1;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // stimulus and predictor state
    in_item_t  interval_queue[$];
    out_item_t table_due[$];
    interval_t held[SET_CAP];
    int        held_count;
    int        sets_solved;
    int        dropped_count;
    int        entries_checked;
    int        mismatch_count;
    int        random_loaded;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    int        mode_left;
    int        rx_tick;
    rx_mode_t  rx_mode;
    out_item_t due_entry;

    weighted_interval_scheduling_core #(
        .MAX_ITEMS(SET_CAP)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #10 aclk = ~aclk;

    // Sort the held set by finish time (stable), build the best-value table
    // and queue one entry per table row.
    task automatic solve_set();
        interval_t        tmp;
        logic [VAL_W-1:0] row[SET_CAP+1];
        logic [31:0]      take;
        out_item_t        entry;
        bit               found;
        for (int pass = 0; pass + 1 < held_count; pass++) begin
            for (int j = 0; j + 1 < held_count - pass; j++) begin
                if (held[j].finish_time > held[j+1].finish_time) begin
                    tmp       = held[j];
                    held[j]   = held[j+1];
                    held[j+1] = tmp;
                end
            end
        end
        row[0] = '0;
        for (int k = 0; k < held_count; k++) begin
            take  = 32'(held[k].weight);
            found = 1'b0;
            for (int i = k - 1; i >= 0; i--) begin
                if (!found && held[i].finish_time <= held[k].start_time) begin
                    take  = take + 32'(row[i+1]);
                    found = 1'b1;
                end
            end
            if (take > 32'(VALUE_CEIL))
                take = 32'(VALUE_CEIL);
            row[k+1] = (take[VAL_W-1:0] > row[k]) ? take[VAL_W-1:0] : row[k];
        end
        for (int k = 0; k <= held_count; k++) begin
            entry.table_index = 5'(k);
            entry.best_value  = row[k];
            entry.last_result = (k == held_count);
            table_due.push_back(entry);
        end
        held_count = 0;
        sets_solved++;
    endtask

    task automatic load_interval(input in_item_t it);
        if (held_count < SET_CAP) begin
            held[held_count].start_time  = it.start_time;
            held[held_count].finish_time = it.finish_time;
            held[held_count].weight      = it.weight;
            held_count++;
        end else begin
            dropped_count++;
        end
        if (it.last)
            solve_set();
    endtask

    task automatic push_interval(input int st, input int fin, input int w, input bit lst);
        in_item_t it;
        it.start_time  = 16'(st);
        it.finish_time = 16'(fin);
        it.weight      = 16'(w);
        it.last        = lst;
        interval_queue.push_back(it);
    endtask

    task automatic add_random_set(input int n, input int span, input bit heavy);
        int a;
        int b;
        int t;
        for (int i = 0; i < n; i++) begin
            a = $urandom_range(0, span);
            b = $urandom_range(0, span);
            // mostly well-formed intervals, a few with start after finish
            if (a > b && $urandom_range(0, 4) != 0) begin
                t = a;
                a = b;
                b = t;
            end
            push_interval(a, b, heavy ? $urandom_range(0, 65535) : $urandom_range(0, 60),
                          i == n - 1);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_item     <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready)
                load_interval(s_item);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (interval_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_item  <= interval_queue.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switches between randomly chosen modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            mode_left = 0;
            rx_tick   = 0;
            rx_mode   = RX_OPEN;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 60);
            end else begin
                mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_tick % 4 == 0);
                default:   m_ready <= (rx_tick % 32 >= 24);
            endcase
        end
    end

    // result check against the oldest due table entry
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            entries_checked++;
            if (table_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected table entry idx=%0d val=%0d last=%0b", $realtime,
                             m_item.table_index, m_item.best_value, m_item.last_result);
                mismatch_count++;
            end else begin
                due_entry = table_due.pop_front();
                if (m_item.table_index != due_entry.table_index ||
                    m_item.best_value != due_entry.best_value ||
                    m_item.last_result != due_entry.last_result) begin
                    if (mismatch_count < 10)
                        $display({"%0t: entry mismatch exp idx=%0d val=%0d last=%0b, ",
                                  "got idx=%0d val=%0d last=%0b"},
                                 $realtime, due_entry.table_index, due_entry.best_value,
                                 due_entry.last_result, m_item.table_index, m_item.best_value,
                                 m_item.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    initial begin
        int n;
        int kind;
        held_count      = 0;
        sets_solved     = 0;
        dropped_count   = 0;
        entries_checked = 0;
        mismatch_count  = 0;
        random_loaded   = 0;
        idle_cycles     = 0;

        // single intervals at both extremes
        push_interval(0, 0, 0, 1'b1);
        push_interval(65535, 65535, 65535, 1'b1);
        // equal finish times keep arrival order; zero-length interval
        push_interval(0, 10, 5, 1'b0);
        push_interval(2, 10, 7, 1'b0);
        push_interval(10, 10, 3, 1'b0);
        push_interval(10, 20, 4, 1'b1);
        // arrives in reverse finish order, endpoints touch
        push_interval(30, 40, 9, 1'b0);
        push_interval(20, 30, 8, 1'b0);
        push_interval(10, 20, 7, 1'b0);
        push_interval(0, 10, 6, 1'b1);
        // start after finish, no compatible predecessor
        push_interval(50, 5, 100, 1'b0);
        push_interval(0, 60, 1, 1'b0);
        push_interval(40, 45, 20, 1'b1);
        // two halves beat one heavy interval, sum wider than 16 bits
        push_interval(0, 100, 65535, 1'b0);
        push_interval(0, 50, 40000, 1'b0);
        push_interval(50, 100, 40000, 1'b1);
        // zero weights only
        push_interval(5, 6, 0, 1'b0);
        push_interval(6, 7, 0, 1'b1);

        // random sets: mostly small, a few full, a few overfilled (extra items dropped)
        while (random_loaded < RANDOM_GOAL) begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                n = SET_CAP;
            else if (kind == 1)
                n = SET_CAP + $urandom_range(1, 4);
            else
                n = $urandom_range(1, 8);
            add_random_set(n, ($urandom_range(0, 3) == 0) ? 65535 : 200,
                           $urandom_range(0, 3) == 0);
            random_loaded += (n < SET_CAP) ? n : SET_CAP;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (interval_queue.size() != 0 || s_valid || table_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        mismatch_count += table_due.size();
        $display("Solved %0d interval sets (%0d intervals dropped on a full store),",
                 sets_solved, dropped_count);
        $display("checked %0d table entries, %0d mismatches.", entries_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
